// ===== rtl/pll_pkg.sv =====
// Shared constants and types for the polyline path length block.
package pll_pkg;

  // Number of coordinates that take part in the distance, 1 to 4.
  localparam int PLL_DIMS   = 4;
  // Number of coordinate fields that every item carries.
  localparam int PLL_NCOORD = 4;

  localparam int COORD_W = 24;                 // signed Q12.12 coordinate
  localparam int ABS_W   = COORD_W + 1;        // magnitude of a coordinate difference
  localparam int SQ_W    = 2 * ABS_W;          // squared difference
  localparam int ACC_W   = SQ_W + 1;           // sum of up to four squares
  localparam int RAD_W   = 52;                 // radicand, even width for the root
  localparam int ROOT_W  = RAD_W / 2;          // segment length, Q14.12
  localparam int REM_W   = ROOT_W + 2;         // partial remainder of the root
  localparam int LEN_W   = 40;                 // running length, Q28.12
  localparam int IDX_W   = $clog2(PLL_NCOORD); // coordinate index
  localparam int ITER_W  = $clog2(ROOT_W);     // root iteration counter

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [PLL_NCOORD-1:0]   coord_vec_t;
  typedef logic [RAD_W-1:0]          rad_t;
  typedef logic [ROOT_W-1:0]         root_t;
  typedef logic [LEN_W-1:0]          len_t;

endpackage

// ===== rtl/pll_in_if.sv =====
// Waypoint channel: valid/ready handshake with four coordinates and an end-of-path flag.
interface pll_in_if;
  logic            valid;
  logic            ready;
  pll_pkg::coord_t coord_0;
  pll_pkg::coord_t coord_1;
  pll_pkg::coord_t coord_2;
  pll_pkg::coord_t coord_3;
  logic            last_point;

  modport source (output valid, output coord_0, output coord_1, output coord_2,
                  output coord_3, output last_point, input ready);
  modport sink   (input valid, input coord_0, input coord_1, input coord_2,
                  input coord_3, input last_point, output ready);
endinterface

// ===== rtl/pll_out_if.sv =====
// Result channel: valid/ready handshake carrying the path length and saturation flag.
interface pll_out_if;
  logic          valid;
  logic          ready;
  pll_pkg::len_t path_length;
  logic          length_saturated;

  modport source (output valid, output path_length, output length_saturated, input ready);
  modport sink   (input valid, input path_length, input length_saturated, output ready);
endinterface

// ===== rtl/polyline_path_length.sv =====
// Polyline path length: sums floor Euclidean segment lengths of a path, one waypoint at a time.
// A path's first waypoint goes straight to the sum step; each later one passes through the
// squared distance unit, the square root and the sum step. Input is taken only when idle.
// The last waypoint of a path waits in the sum step while an older total is held at the output.
// Synchronous active-low reset clears the stored point, the running sum and the output valid.
module polyline_path_length (
  input  logic      clk,
  input  logic      rst_n,
  pll_in_if.sink    in_ch,
  pll_out_if.source out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIST = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;
  localparam logic [1:0] ST_SUM  = 2'd3;

  logic [1:0]          state_r;
  logic [1:0]          state_nxt;
  pll_pkg::coord_vec_t cur_r;
  pll_pkg::coord_vec_t prev_r;
  logic                last_r;
  logic                have_prev_r;
  pll_pkg::len_t       run_r;
  logic                sat_r;
  pll_pkg::root_t      seg_r;
  logic                out_valid_r;
  pll_pkg::len_t       out_len_r;
  logic                out_sat_r;

  pll_pkg::coord_vec_t in_pt;
  pll_pkg::coord_vec_t cur_nxt;
  logic                in_acc;
  logic                dist_start;
  logic                dist_done;
  pll_pkg::rad_t       radicand;
  logic                root_done;
  pll_pkg::root_t      root;
  logic [pll_pkg::LEN_W:0] sum;
  pll_pkg::len_t       run_nxt;
  logic                sat_nxt;
  logic                out_free;
  logic                sum_go;

  assign in_acc = in_ch.valid & in_ch.ready;

  // Gather the coordinates; those beyond the used dimensions read as zero.
  always_comb begin
    in_pt[0] = in_ch.coord_0;
    in_pt[1] = in_ch.coord_1;
    in_pt[2] = in_ch.coord_2;
    in_pt[3] = in_ch.coord_3;
    for (int i = 0; i < pll_pkg::PLL_NCOORD; i++) begin
      cur_nxt[i] = (i < pll_pkg::PLL_DIMS) ? in_pt[i] : '0;
    end
  end

  assign dist_start = in_acc & have_prev_r;

  pll_sqdist u_sqdist (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dist_start),
    .cur      (cur_r),
    .prev     (prev_r),
    .done     (dist_done),
    .radicand (radicand)
  );

  pll_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dist_done),
    .rad   (radicand),
    .done  (root_done),
    .root  (root)
  );

  // Saturating update of the running length.
  always_comb begin
    sum = {1'b0, run_r} + {{(pll_pkg::LEN_W + 1 - pll_pkg::ROOT_W){1'b0}}, seg_r};
    if (sum[pll_pkg::LEN_W]) begin
      run_nxt = '1;
      sat_nxt = 1'b1;
    end else begin
      run_nxt = sum[pll_pkg::LEN_W-1:0];
      sat_nxt = sat_r;
    end
  end

  // The last waypoint waits in the sum state until the output register is free.
  assign out_free = ~out_valid_r | out_ch.ready;
  assign sum_go   = (state_r == ST_SUM) & (~last_r | out_free);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = have_prev_r ? ST_DIST : ST_SUM;
        end
      end
      ST_DIST: begin
        if (dist_done) begin
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (sum_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state, path state and the output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      have_prev_r <= 1'b0;
      run_r       <= '0;
      sat_r       <= 1'b0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (sum_go & last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (sum_go) begin
        if (last_r) begin
          have_prev_r <= 1'b0;
          run_r       <= '0;
          sat_r       <= 1'b0;
          prev_r      <= '0;
        end else begin
          have_prev_r <= 1'b1;
          run_r       <= run_nxt;
          sat_r       <= sat_nxt;
          prev_r      <= cur_r;
        end
      end
    end
  end

  // Item payload, segment length and result registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_r  <= cur_nxt;
      last_r <= in_ch.last_point;
      seg_r  <= '0;
    end else if (root_done) begin
      seg_r <= root;
    end
    if (sum_go & last_r) begin
      out_len_r <= run_nxt;
      out_sat_r <= sat_nxt;
    end
  end

  assign in_ch.ready             = (state_r == ST_IDLE);
  assign out_ch.valid            = out_valid_r;
  assign out_ch.path_length      = out_len_r;
  assign out_ch.length_saturated = out_sat_r;

endmodule

// ===== rtl/pll_sqdist.sv =====
// Squared distance unit: one coordinate per cycle through a shared subtract, square and add.
module pll_sqdist (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  pll_pkg::coord_vec_t cur,
  input  pll_pkg::coord_vec_t prev,
  output logic                done,
  output pll_pkg::rad_t       radicand
);

  logic                         issue_r;
  logic [pll_pkg::IDX_W-1:0]    idx_r;
  logic                         absd_v_r;
  logic                         absd_last_r;
  logic [pll_pkg::ABS_W-1:0]    absd_r;
  logic                         sq_v_r;
  logic                         sq_last_r;
  logic [pll_pkg::SQ_W-1:0]     sq_r;
  logic [pll_pkg::ACC_W-1:0]    acc_r;
  logic                         done_r;

  logic signed [pll_pkg::ABS_W-1:0] diff;
  logic [pll_pkg::ABS_W-1:0]        absd_nxt;
  logic                             issue_last;

  // Difference of the selected coordinate pair and its magnitude.
  always_comb begin
    diff     = {cur[idx_r][pll_pkg::COORD_W-1], cur[idx_r]}
             - {prev[idx_r][pll_pkg::COORD_W-1], prev[idx_r]};
    absd_nxt = diff[pll_pkg::ABS_W-1] ? (~diff + 1'b1) : diff;
  end

  assign issue_last = (idx_r == pll_pkg::IDX_W'(pll_pkg::PLL_DIMS - 1));

  // Sequencer and pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r     <= 1'b0;
      idx_r       <= '0;
      absd_v_r    <= 1'b0;
      absd_last_r <= 1'b0;
      sq_v_r      <= 1'b0;
      sq_last_r   <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      absd_v_r    <= issue_r;
      absd_last_r <= issue_r & issue_last;
      sq_v_r      <= absd_v_r;
      sq_last_r   <= absd_v_r & absd_last_r;
      done_r      <= sq_v_r & sq_last_r;
      if (start) begin
        issue_r <= 1'b1;
        idx_r   <= '0;
      end else if (issue_r) begin
        idx_r <= idx_r + 1'b1;
        if (issue_last) begin
          issue_r <= 1'b0;
        end
      end
    end
  end

  // Datapath: magnitude, square, then accumulate.
  always_ff @(posedge clk) begin
    absd_r <= absd_nxt;
    sq_r   <= absd_r * absd_r;
    if (start) begin
      acc_r <= '0;
    end else if (sq_v_r) begin
      acc_r <= acc_r + {1'b0, sq_r};
    end
  end

  assign done     = done_r;
  assign radicand = {{(pll_pkg::RAD_W - pll_pkg::ACC_W){1'b0}}, acc_r};

endmodule

// ===== rtl/pll_isqrt.sv =====
// Floor integer square root, one result bit per cycle through a shared trial subtractor.
module pll_isqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  pll_pkg::rad_t  rad,
  output logic           done,
  output pll_pkg::root_t root
);

  logic                          busy_r;
  logic                          done_r;
  logic [pll_pkg::ITER_W-1:0]    cnt_r;
  logic [pll_pkg::RAD_W-1:0]     x_r;
  logic [pll_pkg::REM_W-1:0]     rem_r;
  logic [pll_pkg::ROOT_W-1:0]    root_r;

  logic [pll_pkg::REM_W+1:0]     trial_acc;
  logic [pll_pkg::REM_W+1:0]     trial_sub;
  logic [pll_pkg::REM_W+2:0]     trial;

  // Bring down the next two radicand bits and try to subtract 4*root+1.
  always_comb begin
    trial_acc = {rem_r, x_r[pll_pkg::RAD_W-1 -: 2]};
    trial_sub = {2'b00, root_r, 2'b01};
    trial     = {1'b0, trial_acc} - {1'b0, trial_sub};
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= ~start & busy_r & (cnt_r == pll_pkg::ITER_W'(pll_pkg::ROOT_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == pll_pkg::ITER_W'(pll_pkg::ROOT_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Remainder and root registers.
  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r <= {x_r[pll_pkg::RAD_W-3:0], 2'b00};
      if (!trial[pll_pkg::REM_W+2]) begin
        rem_r  <= trial[pll_pkg::REM_W-1:0];
        root_r <= {root_r[pll_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= trial_acc[pll_pkg::REM_W-1:0];
        root_r <= {root_r[pll_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== dv/polyline_path_length_checker.sv =====
// Checker for the polyline path length block: predicts each path total and compares results.
module polyline_path_length_checker
  import pll_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  pll_in_if    in_mon,
  pll_out_if   out_mon,
  output int   fail_count,
  output int   pending_results
);

  typedef struct packed {
    len_t path_length;
    logic length_saturated;
  } path_total_t;

  localparam len_t LENGTH_CEILING = '1;

  // Predicted state of the block for the path in progress.
  coord_t      prev_point [PLL_NCOORD];
  logic        have_prev;
  len_t        length_sum;
  logic        sum_clipped;
  path_total_t expected_totals [$];
  int          fails;

  // Largest r with r * r not above the radicand, found one bit at a time from the top.
  function automatic logic [63:0] segment_root(input logic [63:0] radicand);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= radicand) begin
        root = trial;
      end
    end
    return root;
  endfunction

  always @(posedge clk) begin : watch
    coord_t          pt [PLL_NCOORD];
    longint          diff;
    logic [63:0]     radicand;
    logic [LEN_W:0]  widened;
    path_total_t     total;
    path_total_t     seen;

    if (!rst_n) begin
      for (int d = 0; d < PLL_NCOORD; d++) begin
        prev_point[d] = '0;
      end
      have_prev   = 1'b0;
      length_sum  = '0;
      sum_clipped = 1'b0;
      expected_totals.delete();
    end else begin
      // Accepted waypoint: add the segment from the stored point, close the path on its end.
      if (in_mon.valid && in_mon.ready) begin
        pt[0] = in_mon.coord_0;
        pt[1] = in_mon.coord_1;
        pt[2] = in_mon.coord_2;
        pt[3] = in_mon.coord_3;
        if (have_prev) begin
          radicand = '0;
          for (int d = 0; d < PLL_DIMS; d++) begin
            diff     = longint'(pt[d]) - longint'(prev_point[d]);
            radicand = radicand + 64'(diff * diff);
          end
          widened = {1'b0, length_sum} + (LEN_W + 1)'(segment_root(radicand));
          if (widened > {1'b0, LENGTH_CEILING}) begin
            length_sum  = LENGTH_CEILING;
            sum_clipped = 1'b1;
          end else begin
            length_sum = widened[LEN_W-1:0];
          end
        end
        for (int d = 0; d < PLL_NCOORD; d++) begin
          prev_point[d] = pt[d];
        end
        have_prev = 1'b1;
        if (in_mon.last_point) begin
          total.path_length      = length_sum;
          total.length_saturated = sum_clipped;
          expected_totals.push_back(total);
          for (int d = 0; d < PLL_NCOORD; d++) begin
            prev_point[d] = '0;
          end
          have_prev   = 1'b0;
          length_sum  = '0;
          sum_clipped = 1'b0;
        end
      end

      // Accepted result: it must match the oldest path total still waiting.
      if (out_mon.valid && out_mon.ready) begin
        seen.path_length      = out_mon.path_length;
        seen.length_saturated = out_mon.length_saturated;
        if (expected_totals.size() == 0) begin
          $display("[%0t] unexpected result: path_length %0d, length_saturated %0b",
                   $time, seen.path_length, seen.length_saturated);
          fails++;
        end else begin
          total = expected_totals.pop_front();
          if (seen.path_length !== total.path_length) begin
            $display("[%0t] path_length mismatch: expected %0d, actual %0d",
                     $time, total.path_length, seen.path_length);
            fails++;
          end
          if (seen.length_saturated !== total.length_saturated) begin
            $display("[%0t] length_saturated mismatch: expected %0b, actual %0b",
                     $time, total.length_saturated, seen.length_saturated);
            fails++;
          end
        end
      end
    end

    fail_count      <= fails;
    pending_results <= expected_totals.size();
  end

endmodule

// ===== dv/polyline_path_length_tb.sv =====
// Testbench top for the polyline path length block: clock, reset, waypoint stimulus and verdict.
module polyline_path_length_tb;
  import pll_pkg::*;

  localparam longint CYCLE_LIMIT   = 8_000_000;
  localparam int     RANDOM_POINTS = 1400;
  localparam int     LONG_HOLD     = 400;
  localparam int     DRAIN_CYCLES  = 80;
  localparam coord_t C_MIN         = coord_t'(24'h800000);
  localparam coord_t C_MAX         = coord_t'(24'h7FFFFF);
  localparam coord_t ONE           = coord_t'(24'd4096);

  typedef enum int {RX_ALWAYS, RX_COIN, RX_RARE_STALL, RX_PERIODIC} rx_mode_e;
  typedef enum int {STEP_NEAR, STEP_WIDE, STEP_CORNER} step_style_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending_results;

  pll_in_if  in_ch ();
  pll_out_if out_ch ();

  polyline_path_length u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  polyline_path_length_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // Clock generation.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog on the total run length.
  longint cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: a long hold-off on request, otherwise a stall pattern that changes mode.
  int       hold_requests = 0;
  int       holds_served = 0;
  int       hold_left = 0;
  rx_mode_e rx_mode = RX_ALWAYS;
  int       rx_mode_left = 0;
  int       rx_tick = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left    = LONG_HOLD - 1;
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(16, 200);
      end
      rx_mode_left--;
      rx_tick++;
      case (rx_mode)
        RX_ALWAYS:     out_ch.ready <= 1'b1;
        RX_COIN:       out_ch.ready <= 1'($urandom_range(0, 1));
        RX_RARE_STALL: out_ch.ready <= ($urandom_range(0, 7) != 0);
        default:       out_ch.ready <= ((rx_tick % 5) < 3);
      endcase
    end
  end

  // Waypoint side: bursts of random length with random gaps, when pacing is on.
  logic pace_sender = 1'b0;
  int   burst_left = 0;
  int   points_sent = 0;

  task automatic offer_waypoint(input coord_vec_t p, input logic last);
    int gap;
    if (pace_sender) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    in_ch.valid      <= 1'b1;
    in_ch.coord_0    <= p[0];
    in_ch.coord_1    <= p[1];
    in_ch.coord_2    <= p[2];
    in_ch.coord_3    <= p[3];
    in_ch.last_point <= last;
    do @(posedge clk); while (!in_ch.ready);
    points_sent++;
  endtask

  // Stop offering and wait until every path total has come back.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  function automatic coord_vec_t waypoint(input coord_t a, input coord_t b,
                                          input coord_t c, input coord_t d);
    coord_vec_t p;
    p[0] = a;
    p[1] = b;
    p[2] = c;
    p[3] = d;
    return p;
  endfunction

  function automatic coord_t corner_coord();
    case ($urandom_range(0, 4))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return '0;
      3:       return '1;
      default: return coord_t'(1);
    endcase
  endfunction

  // One path of random length; most paths take small steps, some wide jumps or corners.
  task automatic offer_random_path();
    int          hops;
    int          pick;
    step_style_e style;
    coord_vec_t  p;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      hops = 1;
    end else if (pick < 85) begin
      hops = $urandom_range(2, 6);
    end else begin
      hops = $urandom_range(7, 20);
    end
    pick  = $urandom_range(0, 99);
    style = (pick < 60) ? STEP_NEAR : (pick < 85) ? STEP_WIDE : STEP_CORNER;
    for (int d = 0; d < PLL_NCOORD; d++) begin
      p[d] = (style == STEP_CORNER) ? corner_coord() : coord_t'($urandom);
    end
    for (int k = 0; k < hops; k++) begin
      if (k > 0) begin
        for (int d = 0; d < PLL_NCOORD; d++) begin
          case (style)
            STEP_NEAR: p[d] = p[d] + coord_t'($urandom_range(0, 8191)) - ONE;
            STEP_WIDE: p[d] = coord_t'($urandom);
            default:   p[d] = corner_coord();
          endcase
        end
      end
      offer_waypoint(p, k == hops - 1);
    end
  endtask

  initial begin : stimulus
    logic hold_done;
    logic drain_done;

    hold_done        = 1'b0;
    drain_done       = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.coord_0    = '0;
    in_ch.coord_1    = '0;
    in_ch.coord_2    = '0;
    in_ch.coord_3    = '0;
    in_ch.last_point = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed paths: single points, the longest segment both ways, zero and one-LSB steps.
    offer_waypoint(waypoint('0, '0, '0, '0), 1'b1);
    offer_waypoint(waypoint(C_MAX, C_MIN, C_MAX, C_MIN), 1'b1);
    offer_waypoint(waypoint(C_MIN, C_MIN, C_MIN, C_MIN), 1'b0);
    offer_waypoint(waypoint(C_MAX, C_MAX, C_MAX, C_MAX), 1'b1);
    offer_waypoint(waypoint(C_MAX, C_MAX, C_MAX, C_MAX), 1'b0);
    offer_waypoint(waypoint(C_MIN, C_MIN, C_MIN, C_MIN), 1'b1);
    offer_waypoint(waypoint('0, '0, '0, '0), 1'b0);
    offer_waypoint(waypoint(coord_t'(3 * ONE), coord_t'(4 * ONE), '0, '0), 1'b0);
    offer_waypoint(waypoint(coord_t'(3 * ONE), coord_t'(4 * ONE), '0, '0), 1'b1);
    offer_waypoint(waypoint('0, '0, '0, '0), 1'b0);
    offer_waypoint(waypoint(coord_t'(1), '0, '0, '0), 1'b0);
    offer_waypoint(waypoint(coord_t'(2), coord_t'(1), '0, '0), 1'b0);
    offer_waypoint(waypoint(coord_t'(3), coord_t'(2), coord_t'(1), '0), 1'b0);
    offer_waypoint(waypoint(coord_t'(4), coord_t'(3), coord_t'(2), coord_t'(1)), 1'b1);
    offer_waypoint(waypoint('1, '1, '1, '1), 1'b0);
    offer_waypoint(waypoint(coord_t'(1), coord_t'(1), coord_t'(1), coord_t'(1)), 1'b1);
    offer_waypoint(waypoint(coord_t'(24'h555555), coord_t'(24'h555555),
                            coord_t'(24'h555555), coord_t'(24'h555555)), 1'b0);
    offer_waypoint(waypoint(coord_t'(24'hAAAAAA), coord_t'(24'hAAAAAA),
                            coord_t'(24'hAAAAAA), coord_t'(24'hAAAAAA)), 1'b1);

    // Random paths, with a long result hold-off and a full drain part way through.
    points_sent = 0;
    pace_sender = 1'b1;
    while (points_sent < RANDOM_POINTS) begin
      if (!hold_done && points_sent >= 500) begin
        hold_done = 1'b1;
        hold_requests <= hold_requests + 1;
        pace_sender = 1'b0;
        repeat (30) offer_random_path();
        pace_sender = 1'b1;
      end else if (!drain_done && points_sent >= 1000) begin
        drain_done = 1'b1;
        wait_for_results();
      end else begin
        offer_random_path();
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pll_pkg.sv
rtl/pll_in_if.sv
rtl/pll_out_if.sv
rtl/pll_sqdist.sv
rtl/pll_isqrt.sv
rtl/polyline_path_length.sv
dv/polyline_path_length_checker.sv
dv/polyline_path_length_tb.sv
